/* hw/rtl/periodic_task_dispatcher_stats_defines.svh */
// Assertion macros for the checker file of the dispatcher.
`ifndef PERIODIC_TASK_DISPATCHER_STATS_DEFINES_SVH
`define PERIODIC_TASK_DISPATCHER_STATS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTDS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dispatcher assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PTDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dispatcher assertion failed");

`endif

/* hw/rtl/ptds_pkg.sv */
`default_nettype none

package ptds_pkg;

  // Number of period registers and slots the register map provides.
  localparam int MAX_SLOTS = 4;

  // Register map: period registers sit below the enable mask.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd4;

  // Reset values of the period registers, in milliseconds.
  localparam logic [15:0] PERIOD_RESET [MAX_SLOTS] = '{16'd250, 16'd500, 16'd1000, 16'd5000};
  localparam logic [MAX_SLOTS-1:0] ENABLE_RESET = 4'hF;

  // Input command codes.
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_POLL    = 2'd1,
    CMD_RUNTIME = 2'd2,
    CMD_READ    = 2'd3
  } ptds_cmd_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RUNTIME,
    ST_READ,
    ST_SCAN,
    ST_NEXT,
    ST_CALC,
    ST_DIV,
    ST_UPD
  } ptds_state_e;

  // One result transaction.
  typedef struct packed {
    logic [1:0]  slot_id;
    logic        dispatched;
    logic [31:0] lateness;
    logic [31:0] skipped_now;
    logic [31:0] run_count;
    logic [31:0] late_total;
    logic [31:0] skipped_total;
    logic [31:0] worst_lateness;
    logic [31:0] worst_runtime;
    logic        last;
  } ptds_result_t;

  // A period of zero behaves as a period of one.
  function automatic logic [15:0] eff_period(input logic [15:0] p);
    return (p == 16'd0) ? 16'd1 : p;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ptds_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle: 32-bit dividend, 16-bit divisor.
module ptds_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [15:0] divisor_i,
  output logic             done_o,
  output logic [31:0]      quotient_o
);

  localparam logic [4:0] LastStep = 5'd31;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d;
  logic [15:0] rem_q, rem_d;
  logic [15:0] div_q, div_d;
  logic [16:0] shifted;
  logic [16:0] trial;
  logic        fits;

  // Shift the next dividend bit into the remainder and try a subtraction.
  assign shifted = {rem_q, num_q[31]};
  assign trial   = shifted - {1'b0, div_q};
  assign fits    = (shifted >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      num_d  = dividend_i;
      rem_d  = 16'd0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      // The remainder stays below the divisor, so 16 bits hold it.
      rem_d = fits ? trial[15:0] : shifted[15:0];
      num_d = {num_q[30:0], fits};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

`default_nettype wire

/* hw/rtl/periodic_task_dispatcher_stats.sv */
// Channel   Handshake                   Payload
// input     in_valid_i / in_ready_o     cmd_i, now_ms_i, slot_sel_i, run_time_ms_i
// result    out_valid_o / out_ready_i   slot_id_o .. worst_runtime_o, last_o
// config    cfg_valid_i / cfg_ready_o   cfg_index_i, cfg_data_i
//
// A start arms the slots one by one and gives no result. A poll scans every slot, then
// takes each due slot in index order: it finds the lateness, runs a late slot through the
// shared one-bit-a-cycle divider and writes the result. The input stays blocked until the
// transaction is done.
// A stalled result holds the sequencer only when the next result is ready to be written.
// Reset clears all statistics and deadlines and restores the register defaults.
`default_nettype none

module periodic_task_dispatcher_stats #(
  parameter int NUM_SLOTS = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [1:0]                     cmd_i,
  input  wire logic [31:0]                    now_ms_i,
  input  wire logic [1:0]                     slot_sel_i,
  input  wire logic [31:0]                    run_time_ms_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [1:0]                          slot_id_o,
  output logic                                dispatched_o,
  output logic [31:0]                         lateness_o,
  output logic [31:0]                         skipped_now_o,
  output logic [31:0]                         run_count_o,
  output logic [31:0]                         late_total_o,
  output logic [31:0]                         skipped_total_o,
  output logic [31:0]                         worst_lateness_o,
  output logic [31:0]                         worst_runtime_o,
  output logic                                last_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ptds_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                    cfg_data_i
);

  import ptds_pkg::*;

  localparam int SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [1:0] LastSlot = 2'(NUM_SLOTS - 1);

  // Configuration registers.
  logic [15:0]          period_q [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] enable_q;

  // Per-slot state.
  logic [31:0] deadline_q [NUM_SLOTS];
  logic [31:0] run_cnt_q  [NUM_SLOTS];
  logic [31:0] late_cnt_q [NUM_SLOTS];
  logic [31:0] skip_cnt_q [NUM_SLOTS];
  logic [31:0] max_late_q [NUM_SLOTS];
  logic [31:0] max_run_q  [NUM_SLOTS];

  // Sequencer.
  ptds_state_e          state_q, state_d;
  logic [1:0]           slot_q, slot_d;
  logic [MAX_SLOTS-1:0] due_q, due_d;
  logic                 sent_q, sent_d;
  logic [31:0]          now_q, rt_q;
  logic [31:0]          diff_q, diff_d;
  logic [31:0]          skip_q, skip_d;

  // Result register.
  logic                 out_valid_q;
  ptds_result_t         out_q, res_d;
  logic                 out_load;
  logic                 out_free;

  // Shared adder and the values around the addressed slot.
  logic [31:0]          alu_a, alu_b, alu_y;
  logic                 alu_sub;
  logic [SlotW-1:0]     idx;
  logic                 slot_ok;
  logic [15:0]          eff;
  logic                 dl_we, stat_we, mr_we;
  logic [31:0]          run_new, late_new, skip_new, maxl_new;
  logic                 is_late;
  logic [MAX_SLOTS-1:0] due_rest;

  // Divider.
  logic                 div_start;
  logic                 div_done;
  logic [31:0]          div_quot;

  assign idx      = slot_q[SlotW-1:0];
  assign slot_ok  = (int'(slot_q) < NUM_SLOTS);
  assign eff      = eff_period(period_q[slot_q]);
  assign out_free = !out_valid_q || out_ready_i;

  // Statistics after a dispatch of the addressed slot.
  assign is_late  = (diff_q != 32'd0);
  assign run_new  = run_cnt_q[idx] + 32'd1;
  assign late_new = late_cnt_q[idx] + {31'd0, is_late};
  assign skip_new = skip_cnt_q[idx] + skip_q;
  assign maxl_new = (diff_q > max_late_q[idx]) ? diff_q : max_late_q[idx];

  // Due slots left once the addressed one is done.
  always_comb begin
    due_rest         = due_q;
    due_rest[slot_q] = 1'b0;
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = now_q;
    alu_b   = 32'd0;
    alu_sub = 1'b0;
    unique case (state_q)
      ST_START: begin
        alu_b = {16'd0, eff};
      end
      ST_SCAN, ST_CALC: begin
        alu_b   = deadline_q[idx];
        alu_sub = 1'b1;
      end
      ST_UPD: begin
        alu_a = deadline_q[idx];
        alu_b = {16'd0, eff};
      end
      default: begin
        alu_b = 32'd0;
      end
    endcase
    alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
  end

  // Next state and control.
  always_comb begin
    state_d   = state_q;
    slot_d    = slot_q;
    due_d     = due_q;
    sent_d    = sent_q;
    diff_d    = diff_q;
    skip_d    = skip_q;
    div_start = 1'b0;
    dl_we     = 1'b0;
    stat_we   = 1'b0;
    mr_we     = 1'b0;
    out_load  = 1'b0;
    res_d     = '0;
    res_d.last = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (ptds_cmd_e'(cmd_i))
            CMD_START: begin
              slot_d  = 2'd0;
              state_d = ST_START;
            end
            CMD_POLL: begin
              slot_d  = 2'd0;
              due_d   = '0;
              sent_d  = 1'b0;
              state_d = ST_SCAN;
            end
            CMD_RUNTIME: begin
              slot_d  = slot_sel_i;
              state_d = ST_RUNTIME;
            end
            CMD_READ: begin
              slot_d  = slot_sel_i;
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_START: begin
        dl_we = 1'b1;
        if (slot_q == LastSlot) begin
          state_d = ST_IDLE;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      ST_RUNTIME: begin
        mr_we   = slot_ok && (rt_q > max_run_q[idx]);
        state_d = ST_IDLE;
      end
      ST_READ: begin
        res_d.slot_id = slot_q;
        if (slot_ok) begin
          res_d.run_count      = run_cnt_q[idx];
          res_d.late_total     = late_cnt_q[idx];
          res_d.skipped_total  = skip_cnt_q[idx];
          res_d.worst_lateness = max_late_q[idx];
          res_d.worst_runtime  = max_run_q[idx];
        end
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // An enabled slot is due when now minus its deadline is not negative.
        due_d[slot_q] = enable_q[slot_q] && !alu_y[31];
        if (slot_q == LastSlot) begin
          slot_d  = 2'd0;
          state_d = ST_NEXT;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      ST_NEXT: begin
        priority if (due_q == '0) begin
          // With nothing due and no result sent, a single empty result closes the poll.
          if (sent_q) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (due_q[slot_q]) begin
          state_d = ST_CALC;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      ST_CALC: begin
        diff_d = alu_y;
        if (alu_y != 32'd0) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          skip_d  = 32'd0;
          state_d = ST_UPD;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          skip_d  = div_quot;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        res_d.slot_id        = slot_q;
        res_d.dispatched     = 1'b1;
        res_d.lateness       = diff_q;
        res_d.skipped_now    = skip_q;
        res_d.run_count      = run_new;
        res_d.late_total     = late_new;
        res_d.skipped_total  = skip_new;
        res_d.worst_lateness = maxl_new;
        res_d.worst_runtime  = max_run_q[idx];
        res_d.last           = (due_rest == '0);
        if (out_free) begin
          out_load = 1'b1;
          dl_we    = 1'b1;
          stat_we  = 1'b1;
          due_d    = due_rest;
          sent_d   = 1'b1;
          state_d  = ST_NEXT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      slot_q  <= 2'd0;
      due_q   <= '0;
      sent_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      due_q   <= due_d;
      sent_q  <= sent_d;
    end
  end

  // Operands of the current transaction.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q <= now_ms_i;
      rt_q  <= run_time_ms_i;
    end
    diff_q <= diff_d;
    skip_q <= skip_d;
  end

  // Configuration registers; writes to unmapped indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SLOTS; i++) begin
        period_q[i] <= PERIOD_RESET[i];
      end
      enable_q <= ENABLE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i < CFG_ENABLE) begin
        period_q[cfg_index_i[1:0]] <= cfg_data_i;
      end else if (cfg_index_i == CFG_ENABLE) begin
        enable_q <= cfg_data_i[MAX_SLOTS-1:0];
      end
    end
  end

  // Per-slot deadlines and statistics.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        deadline_q[i] <= 32'd0;
        run_cnt_q[i]  <= 32'd0;
        late_cnt_q[i] <= 32'd0;
        skip_cnt_q[i] <= 32'd0;
        max_late_q[i] <= 32'd0;
        max_run_q[i]  <= 32'd0;
      end
    end else begin
      if (dl_we) begin
        deadline_q[idx] <= alu_y;
      end
      if (stat_we) begin
        run_cnt_q[idx]  <= run_new;
        late_cnt_q[idx] <= late_new;
        skip_cnt_q[idx] <= skip_new;
        max_late_q[idx] <= maxl_new;
      end
      if (mr_we) begin
        max_run_q[idx] <= rt_q;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_d;
    end
  end

  // Shared divider for the skipped periods.
  ptds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (alu_y),
    .divisor_i  (eff),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign in_ready_o       = (state_q == ST_IDLE);
  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign slot_id_o        = out_q.slot_id;
  assign dispatched_o     = out_q.dispatched;
  assign lateness_o       = out_q.lateness;
  assign skipped_now_o    = out_q.skipped_now;
  assign run_count_o      = out_q.run_count;
  assign late_total_o     = out_q.late_total;
  assign skipped_total_o  = out_q.skipped_total;
  assign worst_lateness_o = out_q.worst_lateness;
  assign worst_runtime_o  = out_q.worst_runtime;
  assign last_o           = out_q.last;

endmodule

`default_nettype wire

/* hw/rtl/ptds_checker.sv */
`default_nettype none

`include "periodic_task_dispatcher_stats_defines.svh"

// Port-level checks of the dispatcher.
module ptds_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  slot_id_o,
  input wire logic        dispatched_o,
  input wire logic [31:0] lateness_o,
  input wire logic [31:0] skipped_now_o,
  input wire logic [31:0] run_count_o,
  input wire logic        last_o
);

  // Each accepted transaction keeps the sequencer busy in the cycle after it is accepted.
  `PTDS_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // A result without a dispatch is a single closing result with no lateness.
  `PTDS_ASSERT_SAME(a_plain_is_last, clk_i, rst_ni, out_valid_o && !dispatched_o, last_o && (lateness_o == 32'd0) && (skipped_now_o == 32'd0))

  // An on-time dispatch skips no period.
  `PTDS_ASSERT_SAME(a_ontime_no_skip, clk_i, rst_ni, out_valid_o && (lateness_o == 32'd0), skipped_now_o == 32'd0)

  // A stalled result holds.
  `PTDS_ASSERT_NEXT(a_result_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(slot_id_o) && $stable(run_count_o) && $stable(last_o))

endmodule

bind periodic_task_dispatcher_stats ptds_checker u_ptds_checker (.*);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ptds_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int RESET_CYCLES = 8;
  // Start gives no result, so a short drain covers it.
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_LIMIT = 4000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  // Tracks slot deadlines and statistics and holds the result transactions still awaited.
  class slot_stats_tracker;
    logic [15:0] period_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] enable_mask;
    logic [31:0] deadline [MAX_SLOTS];
    logic [31:0] run_count [MAX_SLOTS];
    logic [31:0] late_total [MAX_SLOTS];
    logic [31:0] skipped_total [MAX_SLOTS];
    logic [31:0] worst_late [MAX_SLOTS];
    logic [31:0] worst_run [MAX_SLOTS];
    ptds_result_t awaited [$];
    int taken [4];
    int failures;
    int results_seen;
    int dispatches_seen;
    int late_seen;

    function new();
      for (int s = 0; s < MAX_SLOTS; s++) begin
        period_reg[s] = PERIOD_RESET[s];
        deadline[s] = '0;
        run_count[s] = '0;
        late_total[s] = '0;
        skipped_total[s] = '0;
        worst_late[s] = '0;
        worst_run[s] = '0;
      end
      for (int c = 0; c < 4; c++) begin
        taken[c] = 0;
      end
      enable_mask = ENABLE_RESET;
      failures = 0;
      results_seen = 0;
      dispatches_seen = 0;
      late_seen = 0;
    endfunction

    // A zero period register behaves as a period of one.
    function logic [31:0] period_used(int s);
      return (period_reg[s] == 16'd0) ? 32'd1 : {16'd0, period_reg[s]};
    endfunction

    // Period registers sit below the enable mask; unmapped indexes are ignored.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
      if (idx == CFG_ENABLE) begin
        enable_mask = data[MAX_SLOTS-1:0];
      end else if (idx < CFG_ENABLE) begin
        period_reg[idx] = data;
      end
    endfunction

    function ptds_result_t stats_of(int s, logic disp, logic [31:0] lat, logic [31:0] skip,
                                    logic fin);
      ptds_result_t r;
      r.slot_id = 2'(s);
      r.dispatched = disp;
      r.lateness = lat;
      r.skipped_now = skip;
      r.run_count = run_count[s];
      r.late_total = late_total[s];
      r.skipped_total = skipped_total[s];
      r.worst_lateness = worst_late[s];
      r.worst_runtime = worst_run[s];
      r.last = fin;
      return r;
    endfunction

    // Applies one accepted input transaction and queues the results it must produce.
    function void take_command(ptds_cmd_e cmd, logic [31:0] now, logic [1:0] sel,
                               logic [31:0] rt);
      logic [31:0] diff;
      logic [31:0] p;
      logic [31:0] skip;
      ptds_result_t held;
      logic have;
      have = 1'b0;
      held = '0;
      taken[cmd]++;
      case (cmd)
        CMD_START: begin
          // Every slot is armed, enabled or not.
          for (int s = 0; s < MAX_SLOTS; s++) begin
            deadline[s] = now + period_used(s);
          end
        end
        CMD_RUNTIME: begin
          if (rt > worst_run[sel]) begin
            worst_run[sel] = rt;
          end
        end
        CMD_READ: begin
          awaited.push_back(stats_of(sel, 1'b0, '0, '0, 1'b1));
        end
        default: begin
          // Poll: slots in index order, due when the signed distance is not negative.
          for (int s = 0; s < MAX_SLOTS; s++) begin
            diff = now - deadline[s];
            if (enable_mask[s] && !diff[31]) begin
              p = period_used(s);
              skip = '0;
              if (diff != '0) begin
                late_total[s] = late_total[s] + 1;
                if (diff > worst_late[s]) begin
                  worst_late[s] = diff;
                end
                skip = diff / p;
                skipped_total[s] = skipped_total[s] + skip;
              end
              run_count[s] = run_count[s] + 1;
              deadline[s] = deadline[s] + p;
              if (have) begin
                awaited.push_back(held);
              end
              held = stats_of(s, 1'b1, diff, skip, 1'b0);
              have = 1'b1;
            end
          end
          // The final result gets last; with nothing due, the single result is all zero apart from last.
          held.last = 1'b1;
          awaited.push_back(held);
        end
      endcase
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
      end
    endfunction

    // Checks one accepted result transaction against the oldest one awaited.
    function void check_result(ptds_result_t got);
      ptds_result_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("%0t: unexpected result transaction for slot %0d", $time, got.slot_id);
        end
        return;
      end
      want = awaited.pop_front();
      if (want.dispatched) begin
        dispatches_seen++;
        if (want.lateness != '0) begin
          late_seen++;
        end
      end
      compare("slot_id", want.slot_id, got.slot_id);
      compare("dispatched", want.dispatched, got.dispatched);
      compare("lateness", want.lateness, got.lateness);
      compare("skipped_now", want.skipped_now, got.skipped_now);
      compare("run_count", want.run_count, got.run_count);
      compare("late_total", want.late_total, got.late_total);
      compare("skipped_total", want.skipped_total, got.skipped_total);
      compare("worst_lateness", want.worst_lateness, got.worst_lateness);
      compare("worst_runtime", want.worst_runtime, got.worst_runtime);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  ptds_cmd_e in_cmd = CMD_START;
  logic [31:0] in_now = '0;
  logic [1:0] in_sel = '0;
  logic [31:0] in_run = '0;
  logic out_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  logic in_ready;
  logic out_valid;
  logic cfg_ready;
  logic [1:0] slot_id;
  logic dispatched;
  logic [31:0] lateness;
  logic [31:0] skipped_now;
  logic [31:0] run_count;
  logic [31:0] late_total;
  logic [31:0] skipped_total;
  logic [31:0] worst_lateness;
  logic [31:0] worst_runtime;
  logic last;
  ptds_result_t result_bus;

  slot_stats_tracker tracker = new();
  logic [31:0] now_ms = '0;
  int burst_left = 0;
  int gap_max = 0;
  int stall_pct = 0;
  int ready_hold = 0;
  int quiet_cycles = 0;

  always #CLK_HALF clk_i = ~clk_i;

  periodic_task_dispatcher_stats #(
    .NUM_SLOTS(MAX_SLOTS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (in_cmd),
    .now_ms_i        (in_now),
    .slot_sel_i      (in_sel),
    .run_time_ms_i   (in_run),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .slot_id_o       (slot_id),
    .dispatched_o    (dispatched),
    .lateness_o      (lateness),
    .skipped_now_o   (skipped_now),
    .run_count_o     (run_count),
    .late_total_o    (late_total),
    .skipped_total_o (skipped_total),
    .worst_lateness_o(worst_lateness),
    .worst_runtime_o (worst_runtime),
    .last_o          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  assign result_bus = {slot_id, dispatched, lateness, skipped_now, run_count, late_total,
                       skipped_total, worst_lateness, worst_runtime, last};

  // Receiver: holds ready steady for random stretches, stalling at the phase's rate.
  always @(posedge clk_i) begin
    if (ready_hold == 0) begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
      ready_hold <= $urandom_range(0, 7);
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // Check every result transaction as it is accepted.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      tracker.check_result(result_bus);
    end
  end

  // Watchdog: ends the run when no transaction moves on any channel for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("FAIL periodic_task_dispatcher_stats");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Sender: bursts of random length separated by random gaps.
  task automatic push_item(ptds_cmd_e c, logic [31:0] t, logic [1:0] s, logic [31:0] r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= c;
    in_now <= t;
    in_sel <= s;
    in_run <= r;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    tracker.take_command(c, t, s, r);
  endtask

  // Stop sending and wait for every awaited result, then let silent work finish.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Leaves cfg_valid high between back-to-back writes; the caller lowers it.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  task automatic configure(logic [MAX_SLOTS-1:0][15:0] periods, logic [MAX_SLOTS-1:0] mask,
                           logic poke_unmapped);
    settle();
    for (int s = 0; s < MAX_SLOTS; s++) begin
      write_reg(CFG_PERIOD0 + CFG_IDX_W'(s), periods[s]);
    end
    write_reg(CFG_ENABLE, 16'(mask));
    if (poke_unmapped) begin
      write_reg(CFG_UNMAPPED, 16'($urandom));
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly steady polls with time moving forward, plus jumps, restarts, reports and reads.
  task automatic random_stream(int count, int span);
    int pick;
    logic [31:0] stamp;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        now_ms = now_ms + $urandom_range(0, span);
        push_item(CMD_POLL, now_ms, 2'($urandom), $urandom);
      end else if (pick < 63) begin
        stamp = $urandom;
        if ($urandom_range(0, 1) == 1) begin
          now_ms = stamp;
        end
        push_item(CMD_POLL, stamp, 2'($urandom), $urandom);
      end else if (pick < 73) begin
        now_ms = now_ms + $urandom_range(0, 50);
        push_item(CMD_START, now_ms, 2'($urandom), $urandom);
      end else if (pick < 87) begin
        stamp = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(0, 2000);
        push_item(CMD_RUNTIME, $urandom, 2'($urandom), stamp);
      end else begin
        push_item(CMD_READ, $urandom, 2'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset configuration.
    gap_max = 3;
    stall_pct = 20;
    for (int s = 0; s < MAX_SLOTS; s++) begin
      push_item(CMD_READ, '0, 2'(s), '0);
    end
    push_item(CMD_RUNTIME, 32'hFFFF_FFFF, 2'd1, 32'hFFFF_FFFF);
    push_item(CMD_RUNTIME, '0, 2'd2, '0);
    push_item(CMD_RUNTIME, 32'hA5A5_5A5A, 2'd3, 32'h5A5A_A5A5);
    push_item(CMD_READ, '0, 2'd1, '0);
    // Deadlines of zero: a poll at zero dispatches every slot exactly on time.
    push_item(CMD_POLL, '0, 2'd0, '0);
    // Same time again: every deadline is ahead, so nothing is due.
    push_item(CMD_POLL, '0, 2'd3, '0);
    // Arm just below the wrap point, then poll across it.
    push_item(CMD_START, 32'hFFFF_FF00, 2'd0, '0);
    push_item(CMD_POLL, 32'hFFFF_FFFF, 2'd0, '0);
    push_item(CMD_POLL, 32'h0000_13FF, 2'd0, '0);
    // Largest positive distance, then the first negative one.
    push_item(CMD_POLL, tracker.deadline[0] + 32'h7FFF_FFFF, 2'd0, '0);
    push_item(CMD_POLL, tracker.deadline[1] + 32'h8000_0000, 2'd0, '0);
    for (int s = 0; s < MAX_SLOTS; s++) begin
      push_item(CMD_READ, 32'hFFFF_FFFF, 2'(s), 32'hFFFF_FFFF);
    end

    // Shortest, longest and zero periods with the top slot masked off.
    configure({16'($urandom), 16'd0, 16'd65535, 16'd1}, 4'b0111, 1'b0);
    now_ms = $urandom;
    push_item(CMD_START, now_ms, 2'd0, '0);
    random_stream(35, 3000);

    // Short random periods, all slots enabled, no idling on either side.
    configure({16'($urandom_range(1, 100)), 16'($urandom_range(1, 100)),
               16'($urandom_range(1, 100)), 16'($urandom_range(1, 100))}, 4'b1111, 1'b0);
    gap_max = 0;
    stall_pct = 0;
    push_item(CMD_START, now_ms, 2'd0, '0);
    random_stream(22, 150);
    settle();
    random_stream(23, 150);

    // Everything masked: every poll comes back empty. Heavy idling.
    configure({16'd65535, 16'd65535, 16'd65535, 16'd65535}, 4'b0000, 1'b0);
    gap_max = 10;
    stall_pct = 70;
    random_stream(25, 70000);

    // Fully random periods and mask, plus a write to an unmapped index.
    configure({16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)},
              4'($urandom), 1'b1);
    gap_max = 4;
    stall_pct = 50;
    push_item(CMD_START, now_ms, 2'd0, '0);
    random_stream(35, 70000);

    // Period one and huge time steps drive the skip counters through wraparound.
    configure({16'd1, 16'd1, 16'd1, 16'd1}, 4'b1111, 1'b0);
    gap_max = 2;
    stall_pct = 30;
    push_item(CMD_START, now_ms, 2'd0, '0);
    random_stream(25, 32'h7FFF_FFFF);

    settle();
    $display("covered %0d start, %0d poll, %0d runtime and %0d read transactions",
             tracker.taken[CMD_START], tracker.taken[CMD_POLL], tracker.taken[CMD_RUNTIME],
             tracker.taken[CMD_READ]);
    $display("checked %0d results: %0d dispatches, %0d late; %0d mismatches",
             tracker.results_seen, tracker.dispatches_seen, tracker.late_seen,
             tracker.failures);
    if (tracker.failures == 0 && tracker.awaited.size() == 0) begin
      $display("PASS periodic_task_dispatcher_stats");
    end else begin
      $display("FAIL periodic_task_dispatcher_stats");
    end
    $finish;
  end

endmodule
